// File: rtl/core/substring_find_replace_core_defines.svh
// Assertion macros for the substring find-and-replace core.
// Both expect clk and rst_n in scope.
`ifndef SUBSTRING_FIND_REPLACE_CORE_DEFINES_SVH
`define SUBSTRING_FIND_REPLACE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SFR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sfr assertion failed");
`define SFR_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("sfr assertion failed");
`else
`define SFR_ASSERT(label, prop)
`define SFR_ASSERT_NEXT(label, cond, prop)
`endif

`endif

// File: rtl/core/sfr_pkg.sv
package sfr_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int LEN_W       = 4;
    localparam int BYTES_W     = 64;
    localparam int MAX_WIN     = 8;
    localparam int REPORT_W    = 16;
    localparam int RES_IDX_W   = 5;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1,
        CFG_REPL_BYTES     = 2'd2,
        CFG_REPL_LENGTH    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic                has_byte;
        logic                string_done;
        logic [REPORT_W-1:0] replace_count;
        logic                run_last;
    } out_item_t;

    // Configuration with lengths already clamped to their legal range
    typedef struct packed {
        logic [BYTES_W-1:0] pattern_bytes;
        logic [LEN_W-1:0]   pattern_len;
        logic [BYTES_W-1:0] repl_bytes;
        logic [LEN_W-1:0]   repl_len;
    } cfg_t;

    typedef enum logic [1:0] {
        HEAD_NONE,
        HEAD_BYTE,
        HEAD_REPL
    } head_kind_t;

    // One command per input item that causes results
    typedef struct packed {
        head_kind_t          head_kind;
        logic [7:0]          head_byte;
        logic                flush;
        logic [LEN_W-1:0]    flush_cnt;
        logic [BYTES_W-1:0]  flush_bytes;
        logic [REPORT_W-1:0] tally;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

endpackage

// File: rtl/core/substring_find_replace_core.sv
// Streaming find-and-replace over a byte string. The front end takes one byte
// per cycle while the queue has room, keeps a window as long as the pattern and
// compares it in one parallel test; each byte that causes results becomes a
// command in a two-entry queue. The back end turns a command into its results,
// one per cycle while the receiver is ready, through a registered output. A
// byte that causes n results (at most nine: a replacement burst, or a byte and
// a flush of the window, plus the count item) holds the back end until all are
// sent, so the sustained rate is set by the result sequencer, and input stalls
// once the queue is full. An item's first result, when the back end is idle,
// passes the queue entry, the command register and the output register. Write
// configuration only while no item is in flight; no clearing pass follows reset.
`include "substring_find_replace_core_defines.svh"

module substring_find_replace_core #(
    parameter int MAX_PATTERN = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  sfr_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output sfr_pkg::out_item_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [sfr_pkg::BYTES_W-1:0] pattern_bytes_reg, repl_bytes_reg;
    logic [sfr_pkg::LEN_W-1:0]   pattern_length_reg, repl_length_reg;
    sfr_pkg::cfg_t               cfg;
    sfr_pkg::cmd_t               front_cmd, back_cmd;
    logic                        front_cmd_valid, q_push_ready;
    logic                        back_cmd_valid, back_cmd_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= sfr_pkg::LEN_W'(1);
            repl_bytes_reg     <= '0;
            repl_length_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sfr_pkg::CFG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_data;
                sfr_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::CFG_REPL_BYTES:     repl_bytes_reg     <= cfg_data;
                sfr_pkg::CFG_REPL_LENGTH:    repl_length_reg    <= cfg_data[sfr_pkg::LEN_W-1:0];
                default:                     ;
            endcase
        end
    end

    // clamp lengths into range
    always_comb
    begin
        cfg.pattern_bytes = pattern_bytes_reg;
        cfg.repl_bytes    = repl_bytes_reg;
        cfg.pattern_len   = pattern_length_reg;
        if (pattern_length_reg == '0)
        begin
            cfg.pattern_len = sfr_pkg::LEN_W'(1);
        end
        else if (pattern_length_reg > sfr_pkg::LEN_W'(MAX_PATTERN))
        begin
            cfg.pattern_len = sfr_pkg::LEN_W'(MAX_PATTERN);
        end
        cfg.repl_len = (repl_length_reg > sfr_pkg::LEN_W'(sfr_pkg::MAX_WIN))
                     ? sfr_pkg::LEN_W'(sfr_pkg::MAX_WIN) : repl_length_reg;
    end

    sfr_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg       (cfg),
        .cmd_valid (front_cmd_valid),
        .cmd_ready (q_push_ready),
        .cmd_data  (front_cmd)
    );

    sfr_queue #(
        .DEPTH (sfr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_cmd_valid),
        .push_ready (q_push_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_cmd_valid),
        .pop_ready  (back_cmd_ready),
        .pop_data   (back_cmd)
    );

    sfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (back_cmd_valid),
        .cmd_ready (back_cmd_ready),
        .cmd_data  (back_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `SFR_ASSERT(a_term_ends_run, !(out_valid && out_data.string_done) || (out_data.run_last && !out_data.has_byte))
    `SFR_ASSERT(a_byte_no_count, !(out_valid && out_data.has_byte) || (out_data.replace_count == '0 && !out_data.string_done))
    `SFR_ASSERT(a_no_accept_full, !(in_valid && in_ready && !q_push_ready))
    `SFR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

// File: rtl/core/sfr_front.sv
module sfr_front #(
    parameter int MAX_PATTERN = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sfr_pkg::in_item_t in_data,
    input  sfr_pkg::cfg_t    cfg,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output sfr_pkg::cmd_t    cmd_data
);

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);

    logic [7:0]             win_reg [MAX_PATTERN];
    logic [7:0]             win_next [MAX_PATTERN];
    logic [7:0]             win_app [MAX_PATTERN];
    logic [FILL_W-1:0]      fill_reg, fill_next, fill_app, fill_head;
    logic [COUNT_WIDTH-1:0] tally_reg, tally_next, tally_head;
    logic                   accept, full, match, has_result;
    sfr_pkg::head_kind_t    head_kind;
    logic [sfr_pkg::BYTES_W-1:0] flush_bytes;

    always_comb
    begin
        fill_app = (fill_reg < FILL_W'(MAX_PATTERN)) ? fill_reg + FILL_W'(1) : fill_reg;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win_app[i] = (FILL_W'(i) == fill_reg) ? in_data.in_byte : win_reg[i];
        end
        full  = sfr_pkg::LEN_W'(fill_app) >= cfg.pattern_len;
        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((sfr_pkg::LEN_W'(i) < cfg.pattern_len) &&
                (win_app[i] != cfg.pattern_bytes[8*i +: 8]))
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        head_kind  = sfr_pkg::HEAD_NONE;
        fill_head  = fill_app;
        tally_head = tally_reg;
        win_next   = win_app;
        if (full)
        begin
            if (match)
            begin
                head_kind = sfr_pkg::HEAD_REPL;
                fill_head = '0;
                if (tally_reg != '1)
                begin
                    tally_head = tally_reg + COUNT_WIDTH'(1);
                end
            end
            else
            begin
                // emit the oldest byte and shift
                head_kind = sfr_pkg::HEAD_BYTE;
                fill_head = fill_app - FILL_W'(1);
                for (int i = 0; i < MAX_PATTERN - 1; i++)
                begin
                    win_next[i] = win_app[i+1];
                end
            end
        end
        fill_next  = in_data.last_byte ? '0 : fill_head;
        tally_next = in_data.last_byte ? '0 : tally_head;
        has_result = (head_kind == sfr_pkg::HEAD_BYTE) ||
                     ((head_kind == sfr_pkg::HEAD_REPL) && (cfg.repl_len != '0)) ||
                     in_data.last_byte;
    end

    for (genvar g = 0; g < sfr_pkg::MAX_WIN; g++)
    begin : g_flush
        if (g < MAX_PATTERN)
        begin : g_used
            assign flush_bytes[8*g +: 8] = win_next[g];
        end
        else
        begin : g_pad
            assign flush_bytes[8*g +: 8] = 8'd0;
        end
    end

    assign in_ready  = cmd_ready;
    assign accept    = in_valid && in_ready;
    assign cmd_valid = in_valid && has_result;

    always_comb
    begin
        cmd_data.head_kind   = head_kind;
        cmd_data.head_byte   = win_app[0];
        cmd_data.flush       = in_data.last_byte;
        cmd_data.flush_cnt   = sfr_pkg::LEN_W'(fill_head);
        cmd_data.flush_bytes = flush_bytes;
        cmd_data.tally       = sfr_pkg::REPORT_W'(tally_head);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            tally_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg  <= fill_next;
            tally_reg <= tally_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

endmodule

// File: rtl/core/sfr_queue.sv
module sfr_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  sfr_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output sfr_pkg::cmd_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfr_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/sfr_back.sv
module sfr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sfr_pkg::cfg_t      cfg,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  sfr_pkg::cmd_t      cmd_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sfr_pkg::out_item_t out_data
);

    localparam int IW = sfr_pkg::RES_IDX_W;

    sfr_pkg::back_state_t state_reg, state_next;
    sfr_pkg::cmd_t        cmd_reg;
    sfr_pkg::out_item_t   out_reg, item;
    logic                 out_valid_reg;
    logic [IW-1:0]        idx_reg, head_cnt, total, flush_idx;
    logic                 slot_free, emit, at_end, load;

    always_comb
    begin
        case (cmd_reg.head_kind)
            sfr_pkg::HEAD_BYTE: head_cnt = IW'(1);
            sfr_pkg::HEAD_REPL: head_cnt = IW'(cfg.repl_len);
            default:            head_cnt = '0;
        endcase
        total     = head_cnt + (cmd_reg.flush ? IW'(cmd_reg.flush_cnt) + IW'(1) : '0);
        flush_idx = idx_reg - head_cnt;
        at_end    = idx_reg == total - IW'(1);
        slot_free = !out_valid_reg || out_ready;
    end

    // Build the result at the current position of the command
    always_comb
    begin
        item               = '0;
        item.run_last      = at_end;
        if (idx_reg < head_cnt)
        begin
            item.has_byte = 1'b1;
            item.out_byte = (cmd_reg.head_kind == sfr_pkg::HEAD_BYTE) ? cmd_reg.head_byte
                          : cfg.repl_bytes[{idx_reg[2:0], 3'b000} +: 8];
        end
        else if (flush_idx < IW'(cmd_reg.flush_cnt))
        begin
            item.has_byte = 1'b1;
            item.out_byte = cmd_reg.flush_bytes[{flush_idx[2:0], 3'b000} +: 8];
        end
        else
        begin
            item.string_done   = 1'b1;
            item.replace_count = cmd_reg.tally;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfr_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = sfr_pkg::BK_EMIT;
                end
            end
            sfr_pkg::BK_EMIT:
            begin
                if (slot_free && at_end && !cmd_valid)
                begin
                    state_next = sfr_pkg::BK_IDLE;
                end
            end
            default: state_next = sfr_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        emit      = 1'b0;
        cmd_ready = 1'b0;
        case (state_reg)
            sfr_pkg::BK_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            sfr_pkg::BK_EMIT:
            begin
                emit      = slot_free;
                cmd_ready = slot_free && at_end;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign load      = cmd_valid && cmd_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfr_pkg::BK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                idx_reg <= '0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= cmd_data;
        end
        if (emit)
        begin
            out_reg <= item;
        end
    end

endmodule

// File: dv/substring_find_replace_core_tb.sv
module substring_find_replace_core_tb;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int RUN_LIMIT     = 400000;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [63:0] LONG_PATTERN = 64'h807F_00FF_01FE_55AA;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    sfr_pkg::in_item_t   in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    sfr_pkg::out_item_t  out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    sfr_pkg::cfg_index_t cfg_index = sfr_pkg::CFG_PATTERN_BYTES;
    logic [63:0] cfg_data = '0;

    // Shadow of the block: configuration, window and tally
    logic [63:0] pat_bytes = '0;
    logic [3:0]  pat_len   = 4'd1;
    logic [63:0] rep_bytes = '0;
    logic [3:0]  rep_len   = 4'd0;
    logic [7:0]  win [sfr_pkg::MAX_WIN];
    int unsigned win_fill  = 0;
    logic [15:0] tally     = '0;

    sfr_pkg::in_item_t  byte_feed [$];
    sfr_pkg::out_item_t rewritten_due [$];

    int unsigned fed_total   = 0;
    int unsigned taken_total = 0;
    int unsigned n_out       = 0;
    int unsigned err_count   = 0;
    int unsigned stall_cycles = 0;
    int unsigned run_cycles  = 0;
    int          tx_gap  = 0;
    int          tx_calm = 0;
    int          rx_gap  = 0;
    int          rx_calm = 0;
    logic        rx_hold = 1'b0;
    bit          pressure_armed = 1'b0;
    logic [7:0]  sym [3];

    substring_find_replace_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_plen();
        if (pat_len == 4'd0)
            return 1;
        if (pat_len > sfr_pkg::MAX_WIN)
            return sfr_pkg::MAX_WIN;
        return pat_len;
    endfunction

    // A random idle gap before the next item, with the odd calm stretch of no idling at all
    function automatic int draw_gap(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 7);
    endfunction

    function automatic void rewrite_byte(sfr_pkg::in_item_t item);
        sfr_pkg::out_item_t burst [$];
        sfr_pkg::out_item_t r;
        int unsigned plen;
        int unsigned rlen;
        int unsigned k;
        bit          hit;
        plen = eff_plen();
        rlen = (rep_len > 4'd8) ? 8 : rep_len;
        r = '0;
        r.has_byte = 1'b1;
        if (win_fill < sfr_pkg::MAX_WIN)
        begin
            win[win_fill] = item.in_byte;
            win_fill++;
        end
        if (win_fill >= plen)
        begin
            // only the oldest plen bytes take part, even if the window is longer
            hit = 1'b1;
            for (k = 0; k < plen; k++)
                if (win[k] != pat_bytes[8*k +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                for (k = 0; k < rlen; k++)
                begin
                    r.out_byte = rep_bytes[8*k +: 8];
                    burst.push_back(r);
                end
                win_fill = 0;
                if (tally != '1)
                    tally++;
            end
            else
            begin
                r.out_byte = win[0];
                burst.push_back(r);
                for (k = 0; k < sfr_pkg::MAX_WIN - 1; k++)
                    win[k] = win[k + 1];
                win_fill--;
            end
        end
        if (item.last_byte)
        begin
            for (k = 0; k < win_fill; k++)
            begin
                r.out_byte = win[k];
                burst.push_back(r);
            end
            r = '0;
            r.string_done   = 1'b1;
            r.replace_count = tally;
            burst.push_back(r);
            win_fill = 0;
            tally    = '0;
        end
        for (k = 0; k < burst.size(); k++)
        begin
            r = burst[k];
            r.run_last = (k == burst.size() - 1);
            rewritten_due.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic feed(input logic [7:0] b, input logic l);
        sfr_pkg::in_item_t item;
        item.in_byte   = b;
        item.last_byte = l;
        byte_feed.push_back(item);
        fed_total++;
    endtask

    // Wait until every item is taken and every result has come, then let the
    // block finish any quiet item still in its pipeline
    task automatic settle();
        while (taken_total != fed_total || rewritten_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input sfr_pkg::cfg_index_t idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sfr_pkg::CFG_PATTERN_BYTES:  pat_bytes = val;
            sfr_pkg::CFG_PATTERN_LENGTH: pat_len   = val[3:0];
            sfr_pkg::CFG_REPL_BYTES:     rep_bytes = val;
            sfr_pkg::CFG_REPL_LENGTH:    rep_len   = val[3:0];
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin : tx_driver
        bit took;
        took = in_valid && in_ready;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (took)
            begin
                rewrite_byte(in_data);
                taken_total++;
            end
            if (in_valid && !took)
            begin
                // hold the item until it is taken
            end
            else if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (byte_feed.size() != 0)
            begin
                in_data  <= byte_feed.pop_front();
                in_valid <= 1'b1;
                tx_gap = draw_gap(tx_calm);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : rx_monitor
        sfr_pkg::out_item_t want;
        string     bad;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_out++;
                if (rewritten_due.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d with none due: %h", n_out, out_data));
                end
                else
                begin
                    want = rewritten_due.pop_front();
                    bad = "";
                    if (out_data.out_byte !== want.out_byte)
                        bad = {bad, " out_byte"};
                    if (out_data.has_byte !== want.has_byte)
                        bad = {bad, " has_byte"};
                    if (out_data.string_done !== want.string_done)
                        bad = {bad, " string_done"};
                    if (out_data.replace_count !== want.replace_count)
                        bad = {bad, " replace_count"};
                    if (out_data.run_last !== want.run_last)
                        bad = {bad, " run_last"};
                    if (bad != "")
                        report_mismatch($sformatf("result %0d%s: got %h want %h",
                                                  n_out, bad, out_data, want));
                end
                rx_gap = draw_gap(rx_calm);
            end
            if (rx_hold)
            begin
                out_ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so the command queue fills and input stalls
    initial
    begin : rx_pressure
        wait (pressure_armed);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin : watchdog
        run_cycles++;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT || run_cycles >= RUN_LIMIT)
        begin
            $display("substring_find_replace_core_tb: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [7:0]  s [$];
        logic [63:0] word;
        int unsigned k;
        int unsigned cut;
        int unsigned pick;
        int unsigned target;
        int unsigned plen_raw;
        int unsigned rlen_raw;
        int unsigned phase;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Two-byte pattern, full eight-byte replacement, mismatches that shift
        write_reg(sfr_pkg::CFG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_6261);
        write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'd2);
        write_reg(sfr_pkg::CFG_REPL_BYTES, 64'hFF00_A5C3_0102_7F80);
        write_reg(sfr_pkg::CFG_REPL_LENGTH, 64'd8);
        feed(8'h00, 1'b0);
        feed(8'h61, 1'b0);
        feed(8'h62, 1'b0);
        feed(8'h61, 1'b0);
        feed(8'h61, 1'b0);
        feed(8'h62, 1'b0);
        feed(8'hFF, 1'b1);
        settle();

        // Zero pattern length acts as one; zero replacement length deletes
        write_reg(sfr_pkg::CFG_PATTERN_BYTES, 64'h0000_0000_0000_00FF);
        write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'd0);
        write_reg(sfr_pkg::CFG_REPL_LENGTH, 64'd0);
        feed(8'hFF, 1'b0);
        feed(8'h12, 1'b0);
        feed(8'hFF, 1'b1);
        settle();

        // Oversized lengths clamp to eight; full match then a miss on the final byte
        write_reg(sfr_pkg::CFG_PATTERN_BYTES, LONG_PATTERN);
        write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'd15);
        write_reg(sfr_pkg::CFG_REPL_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(sfr_pkg::CFG_REPL_LENGTH, 64'd12);
        for (k = 0; k < 8; k++)
            feed(LONG_PATTERN[8*k +: 8], k == 7);
        settle();
        for (k = 0; k < 7; k++)
            feed(LONG_PATTERN[8*k +: 8], 1'b0);
        feed(LONG_PATTERN[63:56] ^ 8'h01, 1'b1);
        settle();

        // Shorten the pattern while the window holds more bytes than it needs
        write_reg(sfr_pkg::CFG_PATTERN_BYTES, 64'h0000_0000_7A79_7877);
        write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'd4);
        feed(8'h10, 1'b0);
        feed(8'h20, 1'b0);
        feed(8'h30, 1'b0);
        settle();
        write_reg(sfr_pkg::CFG_PATTERN_BYTES, 64'h0000_0000_0000_2010);
        write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'd2);
        feed(8'h40, 1'b1);
        settle();

        // Random phases: strings built mostly from whole and partial patterns
        phase = 0;
        while (fed_total < 280)
        begin
            for (k = 0; k < 3; k++)
                sym[k] = 8'($urandom_range(0, 255));
            plen_raw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(1, 4);
            rlen_raw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 3);
            if (phase == 3)
            begin
                plen_raw = 1;
                rlen_raw = 8;
            end
            word = {$urandom, $urandom};
            for (k = 0; k < 8; k++)
                if ($urandom_range(0, 3) != 0)
                    word[8*k +: 8] = sym[$urandom_range(0, 2)];
            write_reg(sfr_pkg::CFG_PATTERN_BYTES, word);
            word = {$urandom, $urandom};
            word[3:0] = 4'(plen_raw);
            write_reg(sfr_pkg::CFG_PATTERN_LENGTH, word);
            write_reg(sfr_pkg::CFG_REPL_BYTES, {$urandom, $urandom});
            word = {$urandom, $urandom};
            word[3:0] = 4'(rlen_raw);
            write_reg(sfr_pkg::CFG_REPL_LENGTH, word);
            if (phase == 3)
                pressure_armed = 1'b1;

            repeat ($urandom_range(1, 3))
            begin
                s.delete();
                target = $urandom_range(1, 24);
                while (s.size() < target)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                    begin
                        for (k = 0; k < eff_plen(); k++)
                            s.push_back(pat_bytes[8*k +: 8]);
                    end
                    else if (pick < 6)
                    begin
                        cut = $urandom_range(1, eff_plen());
                        for (k = 0; k < cut; k++)
                            s.push_back(pat_bytes[8*k +: 8]);
                    end
                    else if (pick < 9)
                    begin
                        s.push_back(sym[$urandom_range(0, 2)]);
                    end
                    else
                    begin
                        s.push_back(8'($urandom_range(0, 255)));
                    end
                end
                for (k = 0; k < s.size(); k++)
                    feed(s[k], k == s.size() - 1);
            end
            settle();
            phase++;
        end

        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("substring_find_replace_core_tb: PASS");
        else
            $display("substring_find_replace_core_tb: FAIL");
        $finish;
    end

endmodule
